// File: rtl/sbdda_pkg.sv
// Shared constants, types and command/status structs for the stretch coordinate generator.
package sbdda_pkg;

    localparam int DIM_W   = 15;
    localparam int POS_W   = 16;
    localparam int FRAC_W  = 32;
    localparam int STEP_W  = POS_W + FRAC_W;
    localparam int NUM_W   = DIM_W + FRAC_W;
    localparam int PROD_W  = STEP_W + DIM_W;
    localparam int CNT_W   = 6;
    localparam int ADDR_W  = 3;

    localparam logic [ADDR_W-1:0] REG_SRC_W  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_SRC_H  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_DST_W  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_DST_H  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_CLIP_L = 3'd4;
    localparam logic [ADDR_W-1:0] REG_CLIP_T = 3'd5;
    localparam logic [ADDR_W-1:0] REG_CLIP_R = 3'd6;
    localparam logic [ADDR_W-1:0] REG_CLIP_B = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic div_start;
        logic div_y;
        logic step_we;
        logic mul;
        logic seed;
        logic axis_y;
        logic emit_pixel;
        logic emit_empty;
    } sbdda_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clip_empty;
        logic active;
        logic div_done;
        logic slot_free;
    } sbdda_stat_t;

endpackage

// File: rtl/sbdda_div.sv
// Restoring divider, one quotient bit per cycle, for the step computation.
module sbdda_div
    import sbdda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DIM_W-1:0]  den,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  den_reg, den_next;
    logic              done_reg, done_next;
    logic [DIM_W:0]    trial;
    logic              ge;

    // One shift-and-subtract step of the partial remainder.
    always_comb
    begin
        trial = {rem_reg, q_reg[NUM_W-1]};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[NUM_W-2:0], ge};
            rem_next = ge ? DIM_W'(trial - {1'b0, den_reg}) : trial[DIM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: rtl/sbdda_ctrl.sv
// Sequencer for blit setup and per-pixel word issue.
module sbdda_ctrl
    import sbdda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        restart,
    output logic        in_ready,
    input  sbdda_stat_t st,
    output sbdda_cmd_t  cmd
);

    localparam logic [2:0] S_READY = 3'd0;
    localparam logic [2:0] S_DIVX  = 3'd1;
    localparam logic [2:0] S_MULX  = 3'd2;
    localparam logic [2:0] S_SEEDX = 3'd3;
    localparam logic [2:0] S_DIVY  = 3'd4;
    localparam logic [2:0] S_MULY  = 3'd5;
    localparam logic [2:0] S_SEEDY = 3'd6;
    localparam logic [2:0] S_FIRST = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_READY) && st.slot_free;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_READY:
            begin
                if (in_valid && st.slot_free)
                begin
                    if (restart)
                    begin
                        cmd.latch = 1'b1;
                        if (st.clip_empty)
                        begin
                            cmd.emit_empty = 1'b1;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIVX;
                        end
                    end
                    else if (st.active)
                    begin
                        cmd.emit_pixel = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_empty = 1'b1;
                    end
                end
            end
            S_DIVX:
            begin
                if (st.div_done)
                begin
                    cmd.step_we = 1'b1;
                    state_next  = S_MULX;
                end
            end
            S_MULX:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SEEDX;
            end
            S_SEEDX:
            begin
                cmd.seed      = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_y     = 1'b1;
                state_next    = S_DIVY;
            end
            S_DIVY:
            begin
                cmd.axis_y = 1'b1;
                if (st.div_done)
                begin
                    cmd.step_we = 1'b1;
                    state_next  = S_MULY;
                end
            end
            S_MULY:
            begin
                cmd.axis_y = 1'b1;
                cmd.mul    = 1'b1;
                state_next = S_SEEDY;
            end
            S_SEEDY:
            begin
                cmd.axis_y = 1'b1;
                cmd.seed   = 1'b1;
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                if (st.slot_free)
                begin
                    cmd.emit_pixel = 1'b1;
                    state_next     = S_READY;
                end
            end
            default:
            begin
                state_next = S_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_READY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/sbdda_dp.sv
// Datapath: configuration registers, step setup, coordinate accumulators and output word.
module sbdda_dp
    import sbdda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]  cfg_wdata,
    input  sbdda_cmd_t        cmd,
    output sbdda_stat_t       st,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic              m_tlast,
    output logic [2:0]        m_tuser
);

    logic [DIM_W-1:0] cfg_reg [8];

    // Latched blit geometry.
    logic [DIM_W-1:0] sh_reg, dh_reg, x0_reg, y0_reg, x1_reg, y1_reg;
    logic [STEP_W-1:0] x_step_reg, y_step_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [POS_W-1:0]  row_start_col_reg, cur_src_col_reg, cur_src_row_reg;
    logic [POS_W-1:0]  prev_src_row_reg, cur_dst_col_reg, cur_dst_row_reg;
    logic [FRAC_W-1:0] row_start_frac_reg, x_frac_reg, y_frac_reg;
    logic              active_reg, have_prev_reg, out_valid_reg;
    logic [63:0]       out_data_reg;
    logic              out_last_reg;
    logic [2:0]        out_user_reg;

    logic [DIM_W-1:0]  sw, sh, dw, dh, x1, y1;
    logic [NUM_W-1:0]  div_num, quot;
    logic [DIM_W-1:0]  div_den;
    logic              div_done;
    logic [STEP_W-1:0] step_sel;
    logic [PROD_W:0]   seed_pos;
    logic              rend, bend, rep;
    logic [FRAC_W:0]   fsum;
    logic [POS_W-1:0]  pos_adv;

    function automatic logic [DIM_W-1:0] dim(input logic [DIM_W-1:0] v);
        dim = (v == '0) ? DIM_W'(1) : v;
    endfunction

    // Effective sizes and clip bounds from the live registers.
    always_comb
    begin
        sw = dim(cfg_reg[REG_SRC_W]);
        sh = dim(cfg_reg[REG_SRC_H]);
        dw = dim(cfg_reg[REG_DST_W]);
        dh = dim(cfg_reg[REG_DST_H]);
        x1 = (cfg_reg[REG_CLIP_R] < dw) ? cfg_reg[REG_CLIP_R] : dw;
        y1 = (cfg_reg[REG_CLIP_B] < dh) ? cfg_reg[REG_CLIP_B] : dh;
    end

    // Step divider: x operands come live at restart, y operands from the latch.
    assign div_num = cmd.div_y ? ({sh_reg, {FRAC_W{1'b0}}} - 1'b1)
                               : ({sw, {FRAC_W{1'b0}}} - 1'b1);
    assign div_den = cmd.div_y ? dh_reg : dw;

    sbdda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    assign step_sel = cmd.axis_y ? y_step_reg : x_step_reg;
    assign seed_pos = {1'b0, prod_reg} + (PROD_W+1)'(step_sel >> 1);

    // Per-pixel decisions and the shared accumulator add.
    always_comb
    begin
        rend = ({1'b0, cur_dst_col_reg} + 1'b1) >= {2'b0, x1_reg};
        bend = rend && (({1'b0, cur_dst_row_reg} + 1'b1) >= {2'b0, y1_reg});
        rep  = have_prev_reg && (prev_src_row_reg == cur_src_row_reg);
        if (rend)
        begin
            fsum    = {1'b0, y_frac_reg} + {1'b0, y_step_reg[FRAC_W-1:0]};
            pos_adv = cur_src_row_reg + y_step_reg[STEP_W-1:FRAC_W]
                      + POS_W'(fsum[FRAC_W]);
        end
        else
        begin
            fsum    = {1'b0, x_frac_reg} + {1'b0, x_step_reg[FRAC_W-1:0]};
            pos_adv = cur_src_col_reg + x_step_reg[STEP_W-1:FRAC_W]
                      + POS_W'(fsum[FRAC_W]);
        end
    end

    assign st.clip_empty = (x1 <= cfg_reg[REG_CLIP_L]) || (y1 <= cfg_reg[REG_CLIP_T]);
    assign st.active     = active_reg;
    assign st.div_done   = div_done;
    assign st.slot_free  = !out_valid_reg || m_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_SRC_W]  <= DIM_W'(1);
            cfg_reg[REG_SRC_H]  <= DIM_W'(1);
            cfg_reg[REG_DST_W]  <= DIM_W'(1);
            cfg_reg[REG_DST_H]  <= DIM_W'(1);
            cfg_reg[REG_CLIP_L] <= '0;
            cfg_reg[REG_CLIP_T] <= '0;
            cfg_reg[REG_CLIP_R] <= '1;
            cfg_reg[REG_CLIP_B] <= '1;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Control flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit_pixel || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.latch)
            begin
                active_reg    <= 1'b0;
                have_prev_reg <= 1'b0;
            end
            else if (cmd.seed && cmd.axis_y)
            begin
                active_reg <= 1'b1;
            end
            else if (cmd.emit_pixel)
            begin
                if (bend)
                begin
                    active_reg <= 1'b0;
                end
                else if (rend)
                begin
                    have_prev_reg <= 1'b1;
                end
            end
        end
    end

    // Geometry, steps, accumulators and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sh_reg           <= sh;
            dh_reg           <= dh;
            x0_reg           <= cfg_reg[REG_CLIP_L];
            y0_reg           <= cfg_reg[REG_CLIP_T];
            x1_reg           <= x1;
            y1_reg           <= y1;
            prev_src_row_reg <= '0;
        end
        if (cmd.step_we)
        begin
            if (cmd.axis_y)
            begin
                y_step_reg <= {1'b0, quot} + 1'b1;
            end
            else
            begin
                x_step_reg <= {1'b0, quot} + 1'b1;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= step_sel * (cmd.axis_y ? y0_reg : x0_reg);
        end
        if (cmd.seed)
        begin
            if (cmd.axis_y)
            begin
                cur_src_row_reg <= seed_pos[FRAC_W +: POS_W];
                y_frac_reg      <= seed_pos[FRAC_W-1:0];
                cur_dst_row_reg <= {1'b0, y0_reg};
            end
            else
            begin
                row_start_col_reg  <= seed_pos[FRAC_W +: POS_W];
                row_start_frac_reg <= seed_pos[FRAC_W-1:0];
                cur_src_col_reg    <= seed_pos[FRAC_W +: POS_W];
                x_frac_reg         <= seed_pos[FRAC_W-1:0];
                cur_dst_col_reg    <= {1'b0, x0_reg};
            end
        end
        if (cmd.emit_empty)
        begin
            out_data_reg <= '0;
            out_last_reg <= 1'b0;
            out_user_reg <= 3'b100;
        end
        if (cmd.emit_pixel)
        begin
            out_data_reg <= {4'b0, cur_dst_row_reg[DIM_W-1:0], cur_dst_col_reg[DIM_W-1:0],
                             cur_src_row_reg[DIM_W-1:0], cur_src_col_reg[DIM_W-1:0]};
            out_last_reg <= rend;
            out_user_reg <= {1'b0, rep, bend};
            if (!bend && rend)
            begin
                prev_src_row_reg <= cur_src_row_reg;
                cur_src_row_reg  <= pos_adv;
                y_frac_reg       <= fsum[FRAC_W-1:0];
                cur_dst_row_reg  <= cur_dst_row_reg + 1'b1;
                cur_dst_col_reg  <= {1'b0, x0_reg};
                cur_src_col_reg  <= row_start_col_reg;
                x_frac_reg       <= row_start_frac_reg;
            end
            else if (!rend)
            begin
                cur_src_col_reg <= pos_adv;
                x_frac_reg      <= fsum[FRAC_W-1:0];
                cur_dst_col_reg <= cur_dst_col_reg + 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: rtl/stretch_blit_coordinate_dda_unit.sv
// Top level of the nearest-neighbor stretch coordinate generator.
// A restart word with a visible clip gives its first pixel word after setup: two step
// divisions on one shared restoring divider, a multiply and a seed step per axis, and an
// issue step that waits for a free output slot. No word is accepted during setup.
// After setup, a pixel word is accepted each cycle while the output is taken; its result,
// like the answer to an empty clip or an idle step, is registered for the next cycle.
// rst_n clears control state asynchronously; the block then is idle.
module stretch_blit_coordinate_dda_unit
    import sbdda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] restart
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // src_col, src_row, dst_col, dst_row
    output logic              m_tlast,   // row_end
    output logic [2:0]        m_tuser    // blit_end, repeat_row, empty_res
);

    sbdda_cmd_t  cmd;
    sbdda_stat_t st;

    sbdda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .restart  (s_tdata[0]),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sbdda_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the stretch blit coordinate generator.
module tb_top
    import sbdda_pkg::*;
();

    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 1700;

    // One result word, split into its fields.
    typedef struct packed {
        bit [14:0] src_col;
        bit [14:0] src_row;
        bit [14:0] dst_col;
        bit [14:0] dst_row;
        bit        row_end;
        bit        blit_end;
        bit        repeat_row;
        bit        empty_res;
    } pixel_t;

    // Scoreboard: tracks the coordinate walk and holds the pixels still owed by the block.
    class coord_scoreboard;
        bit [14:0] regs [8];
        bit [63:0] x_inc, y_inc, x_acc, y_acc, line_frac;
        bit [15:0] line_col, s_col, s_row, last_row, d_col, d_row;
        bit [15:0] first_col, col_end, row_end_lim;
        bit        running, seen_row;
        pixel_t    owed [$];
        int        errors;

        function new();
            regs = '{15'd1, 15'd1, 15'd1, 15'd1, 15'd0, 15'd0, 15'h7fff, 15'h7fff};
            x_inc = 0; y_inc = 0; x_acc = 0; y_acc = 0; line_frac = 0;
            line_col = 0; s_col = 0; s_row = 0; last_row = 0; d_col = 0; d_row = 0;
            first_col = 0; col_end = 0; row_end_lim = 0;
            running = 0; seen_row = 0; errors = 0;
        endfunction

        function void set_reg(int idx, bit [14:0] val);
            regs[idx] = val;
        endfunction

        static function int unsigned size_of(bit [14:0] v);
            return (v == 0) ? 1 : v;
        endfunction

        // Add a fixed-point increment; the fraction carry bumps the integer position.
        function bit [15:0] walk(bit [15:0] pos, inout bit [63:0] frac, input bit [63:0] inc);
            bit [63:0] sum;
            sum = frac + {32'b0, inc[31:0]};
            frac = {32'b0, sum[31:0]};
            return pos + inc[47:32] + {15'b0, sum[32]};
        endfunction

        function bit [63:0] ratio(int unsigned src, int unsigned dst);
            bit [63:0] num;
            num = 64'(src) << 32;
            return (num - 1) / 64'(dst) + 1;
        endfunction

        // Latch the clipped window and seed both axes at half a step past the clip.
        function void begin_blit();
            int unsigned sw, sh, dw, dh, x0, y0, x1, y1;
            bit [63:0] px, py;
            sw = size_of(regs[REG_SRC_W]);
            sh = size_of(regs[REG_SRC_H]);
            dw = size_of(regs[REG_DST_W]);
            dh = size_of(regs[REG_DST_H]);
            x0 = regs[REG_CLIP_L];
            y0 = regs[REG_CLIP_T];
            x1 = (regs[REG_CLIP_R] < dw) ? regs[REG_CLIP_R] : dw;
            y1 = (regs[REG_CLIP_B] < dh) ? regs[REG_CLIP_B] : dh;
            running = 0;
            if (x1 <= x0 || y1 <= y0)
                return;
            x_inc = ratio(sw, dw);
            y_inc = ratio(sh, dh);
            px = (x_inc >> 1) + x_inc * 64'(x0);
            py = (y_inc >> 1) + y_inc * 64'(y0);
            line_col = px[47:32];
            line_frac = {32'b0, px[31:0]};
            x_acc = line_frac;
            s_col = line_col;
            s_row = py[47:32];
            y_acc = {32'b0, py[31:0]};
            d_col = 16'(x0);
            d_row = 16'(y0);
            first_col = 16'(x0);
            col_end = 16'(x1);
            row_end_lim = 16'(y1);
            last_row = 0;
            seen_row = 0;
            running = 1;
        endfunction

        // Note an accepted input word and queue the pixel it produces.
        function void note_word(bit restart);
            pixel_t p;
            p = '0;
            if (restart)
                begin_blit();
            if (!running)
            begin
                p.empty_res = 1;
                owed.push_back(p);
                return;
            end
            p.row_end = (int'(d_col) + 1 >= int'(col_end));
            p.blit_end = p.row_end && (int'(d_row) + 1 >= int'(row_end_lim));
            p.repeat_row = seen_row && (last_row == s_row);
            p.src_col = s_col[14:0];
            p.src_row = s_row[14:0];
            p.dst_col = d_col[14:0];
            p.dst_row = d_row[14:0];
            owed.push_back(p);
            if (p.blit_end)
                running = 0;
            else if (p.row_end)
            begin
                last_row = s_row;
                seen_row = 1;
                s_row = walk(s_row, y_acc, y_inc);
                d_row = d_row + 16'd1;
                d_col = first_col;
                s_col = line_col;
                x_acc = line_frac;
            end
            else
            begin
                s_col = walk(s_col, x_acc, x_inc);
                d_col = d_col + 16'd1;
            end
        endfunction

        // Compare one received word with the oldest owed pixel.
        function void check_word(bit [63:0] data, bit last, bit [2:0] user);
            pixel_t got, want;
            got = {data[14:0], data[29:15], data[44:30], data[59:45],
                   last, user[0], user[1], user[2]};
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word %p", $time, got);
                return;
            end
            want = owed.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
            end
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              cfg_we = 0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [DIM_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;     // [0] restart
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [63:0]       m_tdata;          // src_col, src_row, dst_col, dst_row
    logic              m_tlast;          // row_end
    logic [2:0]        m_tuser;          // blit_end, repeat_row, empty_res

    coord_scoreboard sb = new();
    bit  quiet = 0;
    int  words_sent = 0;
    longint cycles = 0;

    stretch_blit_coordinate_dda_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("stretch_blit_coordinate_dda_unit verification failed");
            $finish;
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast, m_tuser);
    end

    // Output side: random stall before each word, none while quiet.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 8);
            if (n > 0)
            begin
                m_tready <= 0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Send one input word after a random gap.
    task automatic send_word(bit restart);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {7'b0, restart};
        do @(posedge clk); while (!s_tready);
        sb.note_word(restart);
        words_sent++;
    endtask

    // Stop sending and wait until every owed pixel has arrived.
    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Program all eight registers back to back.
    task automatic write_regs(bit [14:0] val [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1;
            cfg_addr <= i[ADDR_W-1:0];
            cfg_wdata <= val[i];
            sb.set_reg(i, val[i]);
            @(posedge clk);
        end
        cfg_we <= 0;
    endtask

    // One blit: a restart followed by pixel words, with optional restarts mid-blit.
    task automatic run_blit(bit [14:0] val [8], int count, bit mid_restart);
        write_regs(val);
        quiet = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < count; i++)
            send_word(i == 0 || (mid_restart && $urandom_range(0, 40) == 0));
        drain();
    endtask

    function automatic bit [14:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 15'h7fff;
            2: return 15'($urandom_range(1, 32767));
            default: return 15'($urandom_range(1, 24));
        endcase
    endfunction

    // Choose a clip span on one axis; visible extent is kept to a dozen pixels.
    task automatic pick_span(int unsigned d, output bit [14:0] lo, output bit [14:0] hi,
                             output int unsigned vis);
        int unsigned e;
        case ($urandom_range(0, 11))
            0:
            begin
                lo = 15'($urandom_range(0, d));
                hi = 15'($urandom_range(0, lo));
            end
            1:
            begin
                lo = (d + 3 > 32767) ? 15'h7fff : 15'(d + $urandom_range(0, 3));
                hi = 15'h7fff;
            end
            2:
            begin
                lo = 15'($urandom);
                hi = 15'($urandom);
            end
            3:
            begin
                lo = 0;
                hi = 15'h7fff;
            end
            default:
            begin
                lo = 15'($urandom_range(0, d - 1));
                hi = 15'(lo + $urandom_range(1, 12));
            end
        endcase
        e = (hi < d) ? hi : d;
        if (e > lo + 12)
        begin
            hi = 15'(lo + $urandom_range(1, 12));
            e = (hi < d) ? hi : d;
        end
        vis = (e > lo) ? e - lo : 0;
    endtask

    initial
    begin
        bit [14:0] val [8];
        int unsigned vw, vh;
        int n;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Reset settings: idle step, a single-pixel blit, then idle again.
        send_word(0);
        send_word(1);
        send_word(0);
        drain();

        // Zero source sizes count as one: a 3x2 destination all from pixel zero.
        val = '{15'd0, 15'd0, 15'd3, 15'd2, 15'd0, 15'd0, 15'h7fff, 15'h7fff};
        run_blit(val, 7, 0);

        // Largest sizes, clipped to the bottom right corner.
        val = '{15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff,
                15'd32764, 15'd32765, 15'h7fff, 15'h7fff};
        run_blit(val, 6, 0);

        // Empty clip: start equals end.
        val = '{15'd4, 15'd4, 15'd8, 15'd8, 15'd5, 15'd0, 15'd5, 15'd8};
        run_blit(val, 2, 0);

        // Clip lying beyond the destination rectangle.
        val = '{15'd7, 15'd3, 15'd2, 15'd2, 15'd4, 15'd0, 15'h7fff, 15'h7fff};
        run_blit(val, 1, 0);

        // Random blits.
        while (words_sent < ITEM_TARGET)
        begin
            for (int i = 0; i < 4; i++)
                val[i] = pick_size();
            pick_span(coord_scoreboard::size_of(val[2]), val[4], val[6], vw);
            pick_span(coord_scoreboard::size_of(val[3]), val[5], val[7], vh);
            n = (vw * vh == 0) ? $urandom_range(1, 3) : vw * vh + $urandom_range(0, 2);
            run_blit(val, n, 1);
        end

        repeat (20) @(posedge clk);
        if (sb.owed.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected words never arrived", $time, sb.owed.size());
        end
        if (sb.errors == 0)
            $display("stretch_blit_coordinate_dda_unit verification clean");
        else
            $display("stretch_blit_coordinate_dda_unit verification failed");
        $finish;
    end

endmodule
